@@ rtl/cfd_pkg.sv @@
package cfd_pkg;

   localparam int DEF_MAX_FRAME = 32;
   localparam int BYTE_W        = 8;
   localparam int LEN_W         = 6;
   localparam int RSP_TDATA_W   = 16;

   typedef enum logic [1:0] {
      STS_ACCEPT = 2'd0,
      STS_ERROR  = 2'd1,
      STS_BYTE   = 2'd2,
      STS_DONE   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_FRAME,
      FSM_DRAIN,
      FSM_DONE
   } fsm_type;

   // Commands from the controller; in idle and frame they are qualified by the request handshake.
   typedef struct packed {
      logic       ld_code;
      logic       store;
      logic       clear;
      logic       drain_start;
      logic       drain;
      logic       put;
      status_type put_status;
   } cmd_type;

   typedef struct packed {
      logic in_zero;
      logic code_long;
      logic fill_full;
      logic at_zero;
      logic zp_long;
      logic drain_empty;
      logic out_free;
   } stat_type;

endpackage

@@ rtl/cfd_ram.sv @@
module cfd_ram
   #(
      parameter int WIDTH = 8,
      parameter int DEPTH = 32
   )
   (
      input  logic                     clock,
      input  logic                     wr_en,
      input  logic [$clog2(DEPTH)-1:0] wr_addr,
      input  logic [WIDTH-1:0]         wr_data,
      input  logic                     rd_en,
      input  logic [$clog2(DEPTH)-1:0] rd_addr,
      output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cfd_ctrl.sv @@
module cfd_ctrl
   import cfd_pkg::*;
   (
      input  logic     clock,
      input  logic     reset,
      input  logic     req_tvalid,
      output logic     req_tready,
      input  stat_type stat,
      output cmd_type  cmd
   );

   fsm_type state_ff;
   fsm_type state_in;
   logic    accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.put_status = STS_ACCEPT;
      req_tready = 1'b0;
      accept     = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_tready = stat.out_free;
            accept     = req_tvalid && stat.out_free;
            if (accept) begin
               cmd.put = 1'b1;
               if (stat.in_zero || stat.code_long) begin
                  cmd.put_status = STS_ERROR;
               end else begin
                  cmd.ld_code    = 1'b1;
                  cmd.put_status = STS_ACCEPT;
                  state_in       = FSM_FRAME;
               end
            end
         end
         FSM_FRAME: begin
            req_tready = stat.out_free;
            accept     = req_tvalid && stat.out_free;
            if (accept) begin
               if (stat.in_zero) begin
                  if (stat.at_zero) begin
                     cmd.drain_start = 1'b1;
                     state_in        = FSM_DRAIN;
                  end else begin
                     cmd.put        = 1'b1;
                     cmd.put_status = STS_ERROR;
                     cmd.clear      = 1'b1;
                     state_in       = FSM_IDLE;
                  end
               end else if (stat.fill_full || (stat.at_zero && stat.zp_long)) begin
                  cmd.put        = 1'b1;
                  cmd.put_status = STS_ERROR;
                  cmd.clear      = 1'b1;
                  state_in       = FSM_IDLE;
               end else begin
                  cmd.store      = 1'b1;
                  cmd.put        = 1'b1;
                  cmd.put_status = STS_ACCEPT;
               end
            end
         end
         FSM_DRAIN: begin
            cmd.drain = 1'b1;
            if (stat.drain_empty) begin
               state_in = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (stat.out_free) begin
               cmd.put        = 1'b1;
               cmd.put_status = STS_DONE;
               cmd.clear      = 1'b1;
               state_in       = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/cfd_datapath.sv @@
module cfd_datapath
   import cfd_pkg::*;
   #(
      parameter int MAX_FRAME = DEF_MAX_FRAME
   )
   (
      input  logic                   clock,
      input  logic                   reset,
      input  cmd_type                cmd,
      output stat_type               stat,
      input  logic [BYTE_W-1:0]      rx_byte,
      input  logic                   rsp_tready,
      output logic                   rsp_tvalid,
      output logic [RSP_TDATA_W-1:0] rsp_tdata,
      output logic [1:0]             rsp_tuser,
      output logic                   rsp_tlast
   );

   localparam int IDX_W = $clog2(MAX_FRAME);
   localparam int CNT_W = $clog2(MAX_FRAME + 1);

   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]  zp_ff, zp_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              out_valid_ff, out_valid_in;
   status_type        out_status_ff, out_status_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;
   logic              out_last_ff, out_last_in;

   logic [8:0]        zp_sum;
   logic [BYTE_W-1:0] code_m1;
   logic              at_zero;
   logic              out_free;
   logic              load_ram;
   logic              issue;
   logic [BYTE_W-1:0] wr_data;
   logic [BYTE_W-1:0] rd_data;

   // The next zero lies at old fill + code, since the stored zero advances the fill by one.
   assign zp_sum   = 9'(fill_ff) + 9'(rx_byte);
   assign code_m1  = rx_byte - 8'd1;
   assign at_zero  = (fill_ff == CNT_W'(zp_ff));
   assign out_free = !out_valid_ff || rsp_tready;
   assign load_ram = cmd.drain && rd_pend_ff && out_free;
   assign issue    = cmd.drain && (rd_idx_ff != fill_ff) && (!rd_pend_ff || load_ram);
   assign wr_data  = at_zero ? '0 : rx_byte;

   assign stat.in_zero     = (rx_byte == '0);
   assign stat.code_long   = (rx_byte > 8'(MAX_FRAME));
   assign stat.fill_full   = (fill_ff >= CNT_W'(MAX_FRAME));
   assign stat.at_zero     = at_zero;
   assign stat.zp_long     = (zp_sum >= 9'(MAX_FRAME));
   assign stat.drain_empty = (rd_idx_ff == fill_ff) && !rd_pend_ff;
   assign stat.out_free    = out_free;

   cfd_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(MAX_FRAME)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.store),
      .wr_addr(fill_ff[IDX_W-1:0]),
      .wr_data(wr_data),
      .rd_en  (issue),
      .rd_addr(rd_idx_ff[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      fill_in = fill_ff;
      zp_in   = zp_ff;
      if (cmd.clear || cmd.ld_code) begin
         fill_in = '0;
      end else if (cmd.store) begin
         fill_in = fill_ff + CNT_W'(1);
      end
      if (cmd.clear) begin
         zp_in = '0;
      end else if (cmd.ld_code) begin
         zp_in = code_m1[IDX_W-1:0];
      end else if (cmd.store && at_zero) begin
         zp_in = zp_sum[IDX_W-1:0];
      end
   end

   always_comb begin
      rd_idx_in  = rd_idx_ff;
      rd_pend_in = rd_pend_ff;
      if (cmd.drain_start) begin
         rd_idx_in  = '0;
         rd_pend_in = 1'b0;
      end else if (issue) begin
         rd_idx_in  = rd_idx_ff + CNT_W'(1);
         rd_pend_in = 1'b1;
      end else if (load_ram) begin
         rd_pend_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_byte_in   = out_byte_ff;
      out_len_in    = out_len_ff;
      out_last_in   = out_last_ff;
      if (load_ram) begin
         out_valid_in  = 1'b1;
         out_status_in = STS_BYTE;
         out_byte_in   = rd_data;
         out_len_in    = '0;
         out_last_in   = 1'b0;
      end else if (cmd.put) begin
         out_valid_in  = 1'b1;
         out_status_in = cmd.put_status;
         out_byte_in   = '0;
         out_len_in    = (cmd.put_status == STS_DONE) ? LEN_W'(fill_ff) : '0;
         out_last_in   = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         zp_ff        <= '0;
         rd_idx_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         zp_ff        <= zp_in;
         rd_idx_ff    <= rd_idx_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_byte_ff   <= out_byte_in;
      out_len_ff    <= out_len_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - LEN_W - BYTE_W)'(0), out_len_ff, out_byte_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ rtl/cobs_frame_decoder.sv @@
// The result of an ordinary byte is in the output register in the cycle after the request.
// Throughput: one request per cycle while the result side keeps up.
// A valid delimiter starts the frame drain: bytes are read from the frame store's registered
// read port into the output register, one byte a cycle while the result side keeps up, and
// the completion follows the last byte; no request is taken during the drain.
// Reset clears the controller, counters and output valid; the frame store is not cleared.
module cobs_frame_decoder
   import cfd_pkg::*;
   #(
      parameter int MAX_FRAME = DEF_MAX_FRAME
   )
   (
      input  logic                   clock,
      input  logic                   reset,
      input  logic                   req_tvalid,
      output logic                   req_tready,
      input  logic [BYTE_W-1:0]      req_tdata,   // [7:0] rx_byte
      output logic                   rsp_tvalid,
      input  logic                   rsp_tready,
      output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [7:0] out_byte, [13:8] frame_length
      output logic [1:0]             rsp_tuser,   // [1:0] status
      output logic                   rsp_tlast
   );

   cmd_type  cmd;
   stat_type stat;

   cfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cfd_datapath #(
      .MAX_FRAME(MAX_FRAME)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .rx_byte   (req_tdata),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

@@ rtl/cfd_checker.sv @@
module cfd_checker
   import cfd_pkg::*;
   (
      input logic                   clock,
      input logic                   reset,
      input logic                   rsp_tvalid,
      input logic                   rsp_tready,
      input logic [RSP_TDATA_W-1:0] rsp_tdata,
      input logic [1:0]             rsp_tuser,
      input logic                   rsp_tlast
   );

   // A stalled result must hold its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // Frame bytes never close a request's results; every other kind does.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != STS_BYTE)))
      else $error("tlast does not match result kind");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STS_BYTE |-> rsp_tdata[7:0] == 8'd0)
      else $error("data byte set on a non-byte result");

   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STS_DONE |-> rsp_tdata[13:8] == 6'd0)
      else $error("length set on a non-completion result");

endmodule

bind cobs_frame_decoder cfd_checker u_cfd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);
